FILE: rtl/olad_pkg.sv
package olad_pkg;

	// Fixed field widths of the request and result channels
	localparam int ACTION_W = 2;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_DUMP   = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEL_LOAD,
		S_DEL_CMP,
		S_DEL_SHIFT,
		S_DUMP_LOAD,
		S_DUMP_EMIT,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   value;
		logic [POS_W-1:0]    position;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} result_t;

endpackage

FILE: rtl/olad_req_if.sv
interface olad_req_if
	import olad_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic signed [DATA_W-1:0]  item_value;

	modport source (output valid, action, item_value, input ready);
	modport sink (input valid, action, item_value, output ready);
endinterface

FILE: rtl/olad_rsp_if.sv
interface olad_rsp_if
	import olad_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [DATA_W-1:0]  entry_value;
	logic [POS_W-1:0]          entry_position;
	logic [COUNT_W-1:0]        entry_count;
	logic                      last_result;

	modport source (output valid, status, entry_value, entry_position, entry_count,
		last_result, input ready);
	modport sink (input valid, status, entry_value, entry_position, entry_count,
		last_result, output ready);
endinterface

FILE: rtl/olad_mem.sv
module olad_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/olad_ctrl.sv
module olad_ctrl
	import olad_pkg::*;
#(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32,
	parameter int IDX_W       = 4,
	parameter int CNT_W       = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	olad_req_if.sink               req,
	olad_rsp_if.source             rsp,
	output logic                   mem_we,
	output logic [IDX_W-1:0]       mem_waddr,
	output logic [VALUE_WIDTH-1:0] mem_wdata,
	output logic [IDX_W-1:0]       mem_raddr,
	input  logic [VALUE_WIDTH-1:0] mem_rdata
);

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       len_q, len_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [VALUE_WIDTH-1:0] value_q;
	result_t                res_q, res_d;
	result_t                out_q, out_d;
	logic                   out_valid_q;
	logic                   out_load;

	logic                   accept;
	logic                   out_free;
	logic                   hit;
	logic                   is_full;
	logic                   is_empty;
	logic [CNT_W-1:0]       idx_ext;
	logic [CNT_W-1:0]       idx_inc;
	logic [CNT_W-1:0]       idx_inc2;
	logic [VALUE_WIDTH-1:0] in_value;

	function automatic result_t make_result(status_t st, logic [DATA_W-1:0] val,
		logic [POS_W-1:0] pos, logic [COUNT_W-1:0] cnt, logic lst);
		result_t r;
		r.status   = st;
		r.value    = val;
		r.position = pos;
		r.count    = cnt;
		r.last     = lst;
		return r;
	endfunction

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Only the low bits of the request value are kept, zero extended
	assign in_value  = VALUE_WIDTH'($unsigned(req.item_value));

	assign idx_ext   = CNT_W'(idx_q);
	assign idx_inc   = idx_ext + CNT_W'(1);
	assign idx_inc2  = idx_ext + CNT_W'(2);
	assign is_full   = (len_q == CNT_W'(CAPACITY));
	assign is_empty  = (len_q == '0);

	// Shared compare unit: entry read last cycle against the request value
	assign hit = (mem_rdata == value_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.action)
						ACT_APPEND: state_d = S_RESP;
						ACT_DELETE: state_d = is_empty ? S_RESP : S_DEL_LOAD;
						ACT_DUMP:   state_d = is_empty ? S_RESP : S_DUMP_LOAD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_DEL_LOAD: state_d = S_DEL_CMP;
			S_DEL_CMP: begin
				if (hit) begin
					state_d = (idx_inc == len_q) ? S_RESP : S_DEL_SHIFT;
				end else if (idx_inc == len_q) begin
					state_d = S_RESP;
				end
			end
			S_DEL_SHIFT: begin
				if (idx_inc2 == len_q) begin
					state_d = S_RESP;
				end
			end
			S_DUMP_LOAD: state_d = S_DUMP_EMIT;
			S_DUMP_EMIT: begin
				if (out_free && (idx_inc == len_q)) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath and memory control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q;
		len_d     = len_q;
		idx_d     = idx_q;
		res_d     = res_q;
		out_load  = 1'b0;
		out_d     = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_d = '0;
					unique case (req.action)
						ACT_APPEND: begin
							if (is_full) begin
								res_d = make_result(ST_FULL, '0, '0, COUNT_W'(len_q), 1'b1);
							end else begin
								mem_we    = 1'b1;
								mem_waddr = IDX_W'(len_q);
								mem_wdata = in_value;
								len_d     = len_q + CNT_W'(1);
								res_d     = make_result(ST_OK, '0, POS_W'(len_q),
									COUNT_W'(len_q + CNT_W'(1)), 1'b1);
							end
						end
						ACT_DELETE: begin
							res_d = make_result(ST_NOT_FOUND, '0, '0, '0, 1'b1);
						end
						ACT_DUMP: begin
							res_d = make_result(ST_EMPTY, '0, '0, '0, 1'b1);
						end
						default: ;
					endcase
				end
			end
			S_DEL_CMP: begin
				if (hit) begin
					res_d     = make_result(ST_OK, '0, POS_W'(idx_q),
						COUNT_W'(len_q - CNT_W'(1)), 1'b1);
					mem_raddr = IDX_W'(idx_inc);
					if (idx_inc == len_q) begin
						len_d = len_q - CNT_W'(1);
					end
				end else if (idx_inc == len_q) begin
					res_d = make_result(ST_NOT_FOUND, '0, '0, COUNT_W'(len_q), 1'b1);
				end else begin
					idx_d     = IDX_W'(idx_inc);
					mem_raddr = IDX_W'(idx_inc);
				end
			end
			S_DEL_SHIFT: begin
				// Entry idx+1 was read last cycle; it moves one place toward the head
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = mem_rdata;
				idx_d     = IDX_W'(idx_inc);
				mem_raddr = IDX_W'(idx_inc2);
				if (idx_inc2 == len_q) begin
					len_d = len_q - CNT_W'(1);
				end
			end
			S_DUMP_EMIT: begin
				out_d = make_result(ST_OK, DATA_W'(mem_rdata), POS_W'(idx_q),
					COUNT_W'(len_q), idx_inc == len_q);
				if (out_free) begin
					out_load  = 1'b1;
					idx_d     = IDX_W'(idx_inc);
					mem_raddr = IDX_W'(idx_inc);
				end
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= in_value;
		end
		res_q <= res_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.entry_value    = out_q.value;
	assign rsp.entry_position = out_q.position;
	assign rsp.entry_count    = out_q.count;
	assign rsp.last_result    = out_q.last;

endmodule

FILE: rtl/ordered_list_append_delete_top.sv
// Ordered list of up to CAPACITY values held in a single-port-write, registered-read
// memory. One request at a time: req.ready is high only while the block is idle, and
// a finished result waits in the output register so a new request can be taken
// before it is collected. Delete searches the entries from the head with one shared
// equality compare through the single memory read port, then moves each later entry
// one place toward the head. Dump emits one entry per cycle while rsp.ready stays
// high. A miss, a full append or an empty dump gives one status result. Action code
// 3 is dropped with no result. Values keep their low VALUE_WIDTH bits and are
// compared as raw bit patterns.
module ordered_list_append_delete_top #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	olad_req_if.sink   req,
	olad_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic [IDX_W-1:0]       mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_rdata;

	// Sequencer, compare unit and output register
	olad_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// Entry store
	olad_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(VALUE_WIDTH),
		.AW   (IDX_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

FILE: rtl/olad_chk.sv
module olad_chk
	import olad_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic [ACTION_W-1:0] req_action,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [DATA_W-1:0]   rsp_entry_value,
	input logic [POS_W-1:0]    rsp_entry_position,
	input logic [COUNT_W-1:0]  rsp_entry_count,
	input logic                rsp_last_result
);

	// An accepted request with a defined action code keeps the block busy for at least the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_action == ACT_APPEND || req_action == ACT_DELETE ||
		req_action == ACT_DUMP) |=> !req_ready)
		else $error("request accepted while a previous one was in progress");

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_entry_value) && $stable(rsp_entry_position) &&
		$stable(rsp_entry_count) && $stable(rsp_last_result))
		else $error("stalled result changed");

	// Status results are single, final and carry no entry
	a_status_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_last_result && rsp_entry_value == '0 &&
		rsp_entry_position == '0)
		else $error("malformed status result");

	// An empty dump reports no entries held
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0)
		else $error("empty status with nonzero count");

endmodule

bind ordered_list_append_delete_top olad_chk u_olad_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_action        (req.action),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_entry_value   (rsp.entry_value),
	.rsp_entry_position(rsp.entry_position),
	.rsp_entry_count   (rsp.entry_count),
	.rsp_last_result   (rsp.last_result)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import olad_pkg::*;

	localparam int LIST_CAP    = 16;
	localparam int MAX_PRINTED = 60;
	// action code with no meaning; the block drops it without a result
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [ACTION_W-1:0]      action;
		logic signed [DATA_W-1:0] value;
		int                       reps;
		bit                       known;
		result_t                  known_result;
	} plan_row_t;

	logic clk;
	logic arst_n;

	olad_req_if req_bus ();
	olad_rsp_if rsp_bus ();

	ordered_list_append_delete_top #(
		.CAPACITY    (LIST_CAP),
		.VALUE_WIDTH (DATA_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// shadow copy of the list and the results still owed by the block
	logic signed [DATA_W-1:0] shadow_list[$];
	result_t                  pending_results[$];
	int                       error_count;
	int                       send_idle_pct;
	int                       recv_stall_pct;
	plan_row_t                directed_plan[16];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic result_t make_result(status_t status, logic [DATA_W-1:0] value,
		int position, int count, bit last);
		result_t r;
		r.status   = status;
		r.value    = value;
		r.position = position[POS_W-1:0];
		r.count    = count[COUNT_W-1:0];
		r.last     = last;
		return r;
	endfunction

	// apply one request to the shadow list and append the results it causes
	function automatic void apply_list_request(logic [ACTION_W-1:0] action,
		logic signed [DATA_W-1:0] value, ref result_t out_q[$]);
		int hit;
		int n;
		hit = -1;
		n   = shadow_list.size();
		case (action)
			ACT_APPEND: begin
				if (n >= LIST_CAP) begin
					out_q.push_back(make_result(ST_FULL, '0, 0, n, 1'b1));
				end else begin
					shadow_list.push_back(value);
					out_q.push_back(make_result(ST_OK, '0, n, n + 1, 1'b1));
				end
			end
			ACT_DELETE: begin
				for (int i = 0; i < n; i++) begin
					if (hit < 0 && shadow_list[i] == value)
						hit = i;
				end
				if (hit < 0) begin
					out_q.push_back(make_result(ST_NOT_FOUND, '0, 0, n, 1'b1));
				end else begin
					shadow_list.delete(hit);
					out_q.push_back(make_result(ST_OK, '0, hit, n - 1, 1'b1));
				end
			end
			ACT_DUMP: begin
				if (n == 0)
					out_q.push_back(make_result(ST_EMPTY, '0, 0, 0, 1'b1));
				for (int i = 0; i < n; i++)
					out_q.push_back(make_result(ST_OK, shadow_list[i], i, n, i == n - 1));
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// one request transfer; drive at the falling edge, accept at the rising edge
	task automatic send_request(logic [ACTION_W-1:0] action, logic signed [DATA_W-1:0] value,
		bit known, result_t known_result);
		result_t scratch[$];
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid = 1'b0;
			@(negedge clk);
		end
		req_bus.valid      = 1'b1;
		req_bus.action     = action;
		req_bus.item_value = value;
		do @(posedge clk); while (!req_bus.ready);
		if (known) begin
			apply_list_request(action, value, scratch);
			pending_results.push_back(known_result);
		end else begin
			apply_list_request(action, value, pending_results);
		end
	endtask

	// stop sending and hold off until the block owes nothing
	task automatic drain_results();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] random_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4)
			return VAL_MIN;
		else if (pick < 8)
			return VAL_MAX;
		else if (pick < 12)
			return -1;
		else if (pick < 50)
			return $urandom_range(12);
		return $urandom;
	endfunction

	// receiver stalls
	always @(negedge clk)
		rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (rsp_bus.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						rsp_bus.status, want.status));
				if (rsp_bus.entry_value !== want.value)
					report_mismatch($sformatf("entry_value %h, want %h",
						rsp_bus.entry_value, want.value));
				if (rsp_bus.entry_position !== want.position)
					report_mismatch($sformatf("entry_position %0d, want %0d",
						rsp_bus.entry_position, want.position));
				if (rsp_bus.entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						rsp_bus.entry_count, want.count));
				if (rsp_bus.last_result !== want.last)
					report_mismatch($sformatf("last_result %0b, want %0b",
						rsp_bus.last_result, want.last));
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int sent;
		int pick;
		logic [ACTION_W-1:0] action;
		logic signed [DATA_W-1:0] value;
		int idle_table[4];
		int stall_table[4];

		error_count        = 0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		arst_n             = 1'b0;
		req_bus.valid      = 1'b0;
		req_bus.action     = ACT_APPEND;
		req_bus.item_value = '0;

		// directed: empty list, duplicates, head/tail removal, full list
		directed_plan[0]  = '{ACT_DUMP, 0, 1, 1'b1, make_result(ST_EMPTY, '0, 0, 0, 1'b1)};
		directed_plan[1]  = '{ACT_DELETE, 0, 1, 1'b1,
			make_result(ST_NOT_FOUND, '0, 0, 0, 1'b1)};
		directed_plan[2]  = '{ACT_UNUSED, 0, 1, 1'b0, make_result(ST_OK, '0, 0, 0, 1'b0)};
		directed_plan[3]  = '{ACT_APPEND, VAL_MIN, 1, 1'b1, make_result(ST_OK, '0, 0, 1, 1'b1)};
		directed_plan[4]  = '{ACT_APPEND, VAL_MAX, 1, 1'b1, make_result(ST_OK, '0, 1, 2, 1'b1)};
		directed_plan[5]  = '{ACT_APPEND, VAL_MIN, 1, 1'b1, make_result(ST_OK, '0, 2, 3, 1'b1)};
		directed_plan[6]  = '{ACT_APPEND, -1, 1, 1'b1, make_result(ST_OK, '0, 3, 4, 1'b1)};
		directed_plan[7]  = '{ACT_DELETE, VAL_MIN, 1, 1'b1, make_result(ST_OK, '0, 0, 3, 1'b1)};
		directed_plan[8]  = '{ACT_DELETE, 7, 1, 1'b1,
			make_result(ST_NOT_FOUND, '0, 0, 3, 1'b1)};
		directed_plan[9]  = '{ACT_DELETE, -1, 1, 1'b1, make_result(ST_OK, '0, 2, 2, 1'b1)};
		directed_plan[10] = '{ACT_APPEND, 32'sh5a5a_0000, 14, 1'b0,
			make_result(ST_OK, '0, 0, 0, 1'b0)};
		directed_plan[11] = '{ACT_APPEND, 0, 1, 1'b1,
			make_result(ST_FULL, '0, 0, LIST_CAP, 1'b1)};
		directed_plan[12] = '{ACT_DUMP, -1, 1, 1'b0, make_result(ST_OK, '0, 0, 0, 1'b0)};
		directed_plan[13] = '{ACT_UNUSED, -1, 1, 1'b0, make_result(ST_OK, '0, 0, 0, 1'b0)};
		directed_plan[14] = '{ACT_DELETE, 32'sh5a5a_000d, 1, 1'b0,
			make_result(ST_OK, '0, 0, 0, 1'b0)};
		directed_plan[15] = '{ACT_DELETE, VAL_MAX, 1, 1'b0, make_result(ST_OK, '0, 0, 0, 1'b0)};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_plan[r]) begin
			for (int k = 0; k < directed_plan[r].reps; k++)
				send_request(directed_plan[r].action, directed_plan[r].value + k,
					directed_plan[r].known, directed_plan[r].known_result);
		end
		send_request(ACT_DUMP, 0, 1'b0, make_result(ST_OK, '0, 0, 0, 1'b0));
		drain_results();

		// random phases: none, sender gaps, receiver stalls, both
		idle_table  = '{0, 51, 0, 38};
		stall_table = '{0, 0, 51, 38};
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = idle_table[phase];
			recv_stall_pct = stall_table[phase];
			sent = 0;
			while (sent < 32) begin
				pick = $urandom_range(99);
				if (pick < 50)
					action = ACT_APPEND;
				else if (pick < 80)
					action = ACT_DELETE;
				else if (pick < 95)
					action = ACT_DUMP;
				else
					action = ACT_UNUSED;
				value = random_value();
				// deletes mostly target a stored value
				if (action == ACT_DELETE && shadow_list.size() != 0 && $urandom_range(99) < 70)
					value = shadow_list[$urandom_range(shadow_list.size() - 1)];
				send_request(action, value, 1'b0, make_result(ST_OK, '0, 0, 0, 1'b0));
				if (action != ACT_UNUSED)
					sent++;
			end
			drain_results();
		end

		repeat (LIST_CAP + 8) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
